// ----- sv/sslc_pkg.sv -----
// shared types, codes and state-update helpers for the stepper shuttle controller
// used by sslc_div, sslc_ctrl, sslc_datapath and the top level
package sslc_pkg;

  localparam logic HALL_POLARITY_LOW = 1'b0;
  localparam logic [31:0] BOTH_DEBOUNCE_MS = 32'd50;
  localparam logic [31:0] NO_END_LIMIT_MS = 32'd0;
  localparam logic [31:0] HOLD_MS = 32'd2000;
  localparam logic [7:0] MAX_RETRIES = 8'd3;
  localparam logic [31:0] UNKNOWN_TRAVEL = 32'd20000;
  localparam logic [31:0] TRAVEL_MARGIN_MS = 32'd5000;
  localparam logic [31:0] NO_END_MARGIN_MS = 32'd2000;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [27:0] US_SPEED_SCALE = 28'd256000000;

  // ramp increment (a*dt*256+500)/1000 equals (32*a*dt+62)/125,
  // the divide by 125 is a multiply by ceil(2^35/125) and a shift by 35
  localparam logic [31:0] RAMP_BIAS = 32'd62;
  localparam logic [28:0] RAMP_RECIP = 29'd274877907;

  // divider lengths in numerator bits
  localparam logic [6:0] LEN_TRAVEL = 7'd42;
  localparam logic [6:0] LEN_IDLE = 7'd1;
  localparam logic [6:0] LEN_MOD = 7'd32;
  localparam logic [6:0] LEN_STEP = 7'd28;

  localparam logic [15:0] RST_MIN_SPEED = 16'd200;
  localparam logic [15:0] RST_MAX_SPEED = 16'd800;
  localparam logic [19:0] RST_ACCEL = 20'd400;
  localparam logic [31:0] RST_DWELL = 32'd1000;
  localparam logic [15:0] RST_REHOME = 16'd10;
  localparam logic [31:0] RST_HOMING_TO = 32'd60000;
  localparam logic [31:0] RST_TRAVEL_TO = 32'd60000;
  localparam logic [31:0] RST_STALL = 32'd2000;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_SPEED = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
  localparam logic [2:0] CFG_ACCEL = 3'd2;
  localparam logic [2:0] CFG_DWELL = 3'd3;
  localparam logic [2:0] CFG_REHOME = 3'd4;
  localparam logic [2:0] CFG_HOMING_TO = 3'd5;
  localparam logic [2:0] CFG_TRAVEL_TO = 3'd6;
  localparam logic [2:0] CFG_STALL = 3'd7;

  // actions
  localparam logic [2:0] A_TICK = 3'd0;
  localparam logic [2:0] A_START = 3'd1;
  localparam logic [2:0] A_STOP = 3'd2;
  localparam logic [2:0] A_HOME = 3'd3;
  localparam logic [2:0] A_LEFT = 3'd4;
  localparam logic [2:0] A_RIGHT = 3'd5;
  localparam logic [2:0] A_FAULT = 3'd6;

  // error codes
  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_BOTH = 3'd1;
  localparam logic [2:0] E_STALL = 3'd2;
  localparam logic [2:0] E_HOMING = 3'd3;
  localparam logic [2:0] E_CALIB = 3'd4;
  localparam logic [2:0] E_TRAVEL = 3'd5;

  typedef enum logic [2:0] {
    M_STOPPED = 3'd0,
    M_HOMING  = 3'd1,
    M_CALIB   = 3'd2,
    M_LEFT    = 3'd3,
    M_RIGHT   = 3'd4,
    M_DWELL   = 3'd5,
    M_FAULT   = 3'd6,
    M_RECOVER = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    PH_NONE, PH_LOAD, PH_PRE, PH_MID, PH_RAMP, PH_FIN
  } phase_t;

  typedef enum logic [1:0] {
    DIV_TRAVEL, DIV_RAMP, DIV_STEP
  } div_sel_t;

  typedef enum logic [3:0] {
    C_IDLE, C_PRE, C_A_GO, C_A_WAIT, C_MID, C_B_GO, C_B_WAIT,
    C_RAMP, C_C_GO, C_C_WAIT, C_FIN, C_OUT
  } ctrl_state_t;

  typedef struct packed {
    phase_t   phase;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic halt;
    logic div_busy;
  } status_t;

  typedef struct packed {
    mode_t       mode;
    mode_t       resume;
    logic [2:0]  err;
    logic [31:0] enter;
    logic [31:0] step_us;
    logic [31:0] ramp_ms;
    logic [31:0] pulse_ms;
    logic [31:0] end_hit;
    logic [31:0] both_since;
    logic [23:0] speed_now;
    logic [23:0] speed_goal;
    logic [31:0] pos;
    logic [31:0] travel;
    logic [31:0] calib;
    logic [31:0] moves;
    logic [31:0] cycles;
    logic        right_seen;
    logic [7:0]  retry;
    logic        locked;
    logic        prev_hl;
    logic        prev_hr;
    logic        prev_act;
    logic        o_pulse;
    logic        o_dir;
    logic        o_event;
  } st_t;

  function automatic st_t f_fault(st_t s, logic [2:0] e, logic [31:0] t);
    st_t r;
    r = s;
    if (r.mode != M_FAULT) begin
      if (r.retry != 8'hFF) r.retry = r.retry + 8'd1;
      r.o_event = 1'b1;
    end
    r.mode = M_FAULT;
    r.err = e;
    r.speed_now = '0;
    r.speed_goal = '0;
    r.enter = t;
    r.locked = (r.retry >= MAX_RETRIES);
    return r;
  endfunction

  function automatic st_t f_stopped(st_t s, logic [31:0] t);
    st_t r;
    r = s;
    r.mode = M_STOPPED;
    r.speed_now = '0;
    r.speed_goal = '0;
    r.enter = t;
    return r;
  endfunction

  function automatic st_t f_homing(st_t s, logic user, logic [15:0] vmin, logic [31:0] t,
                                   logic [31:0] tu);
    st_t r;
    r = s;
    r.mode = M_HOMING;
    r.err = E_NONE;
    r.speed_now = '0;
    r.speed_goal = {vmin, 8'h00};
    r.pos = '0;
    r.enter = t;
    r.step_us = tu;
    r.ramp_ms = t;
    r.pulse_ms = t;
    r.calib = '0;
    r.moves = '0;
    r.right_seen = 1'b0;
    r.travel = '0;
    if (user) begin
      r.retry = '0;
      r.locked = 1'b0;
    end
    return r;
  endfunction

  function automatic st_t f_forced(st_t s, logic right, logic [15:0] vmin, logic [31:0] t,
                                   logic [31:0] tu);
    st_t r;
    r = s;
    r.err = E_NONE;
    r.mode = right ? M_RIGHT : M_LEFT;
    r.speed_goal = {vmin, 8'h00};
    r.speed_now = {vmin, 8'h00};
    r.travel = '0;
    r.moves = '0;
    r.enter = t;
    r.step_us = tu;
    r.ramp_ms = t;
    r.pulse_ms = t;
    return r;
  endfunction

  function automatic st_t f_dwell(st_t s, mode_t next, logic [31:0] t);
    st_t r;
    r = s;
    r.mode = M_DWELL;
    r.resume = next;
    r.enter = t;
    r.speed_now = '0;
    r.speed_goal = '0;
    r.moves = '0;
    return r;
  endfunction

endpackage

// ----- sv/sslc_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on sslc_pkg only for style consistency of the block
module sslc_div
  import sslc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  input  logic [6:0]  len,
  output logic        busy,
  output logic [63:0] quo,
  output logic [31:0] rem
);

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] num_r, num_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    trial = {rem_r, num_r[63]};
    fits = (trial >= {1'b0, den_r});
    if (start) begin
      // left-align the numerator so its top bit enters first
      num_nxt = num << (7'd64 - len);
      cnt_nxt = len;
      rem_nxt = '0;
      quo_nxt = '0;
      den_nxt = den;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quo_nxt = {quo_r[62:0], fits};
      num_nxt = {num_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo = quo_r;
  assign rem = rem_r;

endmodule

// ----- sv/sslc_ctrl.sv -----
// sequencer: walks one tick through its phases and owns both handshakes
// depends on sslc_pkg (ctrl_state_t, cmd_t, status_t)
module sslc_ctrl
  import sslc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.phase = PH_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel = DIV_TRAVEL;
    cmd.out_load = 1'b0;
    in_ready = 1'b0;
    case (state_r)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.phase = PH_LOAD;
          state_nxt = C_PRE;
        end
      end
      C_PRE: begin
        cmd.phase = PH_PRE;
        state_nxt = C_A_GO;
      end
      C_A_GO: begin
        if (st.halt) state_nxt = C_OUT;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_TRAVEL;
          state_nxt = C_A_WAIT;
        end
      end
      C_A_WAIT: if (!st.div_busy) state_nxt = C_MID;
      C_MID: begin
        cmd.phase = PH_MID;
        state_nxt = C_B_GO;
      end
      C_B_GO: begin
        if (st.halt) state_nxt = C_OUT;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_RAMP;
          state_nxt = C_B_WAIT;
        end
      end
      C_B_WAIT: if (!st.div_busy) state_nxt = C_RAMP;
      C_RAMP: begin
        cmd.phase = PH_RAMP;
        state_nxt = C_C_GO;
      end
      C_C_GO: begin
        if (st.halt) state_nxt = C_OUT;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_STEP;
          state_nxt = C_C_WAIT;
        end
      end
      C_C_WAIT: if (!st.div_busy) state_nxt = C_FIN;
      C_FIN: begin
        cmd.phase = PH_FIN;
        state_nxt = C_OUT;
      end
      C_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/sslc_datapath.sv -----
// controller state, timers, ramp arithmetic, limit checks and the result register
// depends on sslc_pkg and sslc_div
module sslc_datapath
  import sslc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_now_us,
  input  logic        in_hall_left_raw,
  input  logic        in_hall_right_raw,
  input  logic        in_system_active,
  input  logic [2:0]  in_fault_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_step_pulse,
  output logic        out_step_dir,
  output logic        out_motor_enable,
  output logic [2:0]  out_motion_state,
  output logic [2:0]  out_error_code,
  output logic signed [31:0] out_position,
  output logic [31:0] out_cycle_count,
  output logic [23:0] out_current_speed,
  output logic [31:0] out_travel_steps,
  output logic        out_permanent_fault,
  output logic        out_fault_event
);

  logic [15:0] min_speed_r, max_speed_r, rehome_r;
  logic [19:0] accel_r;
  logic [31:0] dwell_r, homing_to_r, travel_to_r, stall_r;

  logic [2:0]  act_r, fcode_r;
  logic [31:0] ms_r, us_r;
  logic        hlr_r, hrr_r, sys_r;

  st_t         st_r, st_nxt, st_rst;
  logic        halt_r, halt_nxt;
  logic [51:0] adt_r, ra_r;
  logic [47:0] vv_r;
  logic [31:0] ramp_x;
  logic [60:0] ramp_prod_r;
  logic [25:0] ramp_delta;

  logic        div_busy;
  logic [63:0] div_num, div_quo;
  logic [31:0] div_den, div_rem;
  logic [6:0]  div_len;

  logic [15:0] vmin_eff;
  logic [19:0] accel_eff;
  logic [31:0] steps_lim, done_steps, dt_mid;
  logic [23:0] v_floor;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r <= RST_MIN_SPEED;
      max_speed_r <= RST_MAX_SPEED;
      accel_r <= RST_ACCEL;
      dwell_r <= RST_DWELL;
      rehome_r <= RST_REHOME;
      homing_to_r <= RST_HOMING_TO;
      travel_to_r <= RST_TRAVEL_TO;
      stall_r <= RST_STALL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_SPEED: min_speed_r <= cfg_wdata[15:0];
        CFG_MAX_SPEED: max_speed_r <= cfg_wdata[15:0];
        CFG_ACCEL:     accel_r <= cfg_wdata[19:0];
        CFG_DWELL:     dwell_r <= cfg_wdata;
        CFG_REHOME:    rehome_r <= cfg_wdata[15:0];
        CFG_HOMING_TO: homing_to_r <= cfg_wdata;
        CFG_TRAVEL_TO: travel_to_r <= cfg_wdata;
        CFG_STALL:     stall_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input item capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.phase == PH_LOAD) begin
      act_r <= in_action;
      ms_r <= in_now_ms;
      us_r <= in_now_us;
      hlr_r <= in_hall_left_raw;
      hrr_r <= in_hall_right_raw;
      sys_r <= in_system_active;
      fcode_r <= in_fault_code;
    end
  end

  assign vmin_eff = (min_speed_r != '0) ? min_speed_r : 16'd1;
  assign accel_eff = (accel_r != '0) ? accel_r : 20'd1;
  assign steps_lim = (st_r.travel != '0) ? st_r.travel : UNKNOWN_TRAVEL;
  assign done_steps = (st_r.moves > st_r.travel) ? st_r.travel : st_r.moves;
  assign dt_mid = ms_r - st_r.ramp_ms;
  assign v_floor = (st_r.speed_now < 24'd256) ? 24'd256 : st_r.speed_now;

  // divider operand selection
  always_comb begin
    div_num = '0;
    div_den = 32'd1;
    div_len = LEN_TRAVEL;
    case (cmd.div_sel)
      DIV_TRAVEL: begin
        div_num = {22'd0, 42'(steps_lim) * 42'(MS_PER_S)};
        div_den = {16'd0, vmin_eff};
        div_len = LEN_TRAVEL;
      end
      DIV_RAMP: begin
        if (st_r.mode == M_DWELL) begin
          div_num = {32'd0, st_r.cycles};
          div_den = {16'd0, ((rehome_r != '0) ? rehome_r : 16'd1)};
          div_len = LEN_MOD;
        end else begin
          // moving tick: the increment comes from the reciprocal product
          div_num = '0;
          div_den = 32'd1;
          div_len = LEN_IDLE;
        end
      end
      DIV_STEP: begin
        div_num = {36'd0, US_SPEED_SCALE};
        div_den = {8'd0, v_floor};
        div_len = LEN_STEP;
      end
      default: ;
    endcase
  end

  sslc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .len   (div_len),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // ramp operands, taken in the limit-check phase whether or not the checks pass
  always_ff @(posedge clk) begin
    if (cmd.phase == PH_MID) begin
      adt_r <= 52'(accel_eff) * 52'(dt_mid);
      ra_r <= 52'(st_r.travel - done_steps) * 52'(accel_eff);
      vv_r <= 48'(st_r.speed_now) * 48'(st_r.speed_now);
    end
  end

  // increment is registered from adt_r in the cycle after it; from a*dt of 2^26 up it passes any
  // speed difference, so it saturates there
  assign ramp_x = {1'b0, adt_r[25:0], 5'd0} + RAMP_BIAS;

  always_ff @(posedge clk) begin
    ramp_prod_r <= 61'(ramp_x) * 61'(RAMP_RECIP);
  end

  assign ramp_delta = (adt_r[51:26] != '0) ? 26'h200_0000 : ramp_prod_r[60:35];

  always_comb begin
    st_t         s;
    logic        hl, hr, right, brake;
    logic [31:0] t, tu, dt, lim_trav, lim_noend, lim_move;
    logic [42:0] trav_sum;
    logic [33:0] noend_sum;
    logic [63:0] v, want, vmin64, vmax64, delta;
    s = st_r;
    halt_nxt = halt_r;
    t = ms_r;
    tu = us_r;
    hl = hlr_r ^ HALL_POLARITY_LOW;
    hr = hrr_r ^ HALL_POLARITY_LOW;
    right = 1'b0;
    brake = 1'b0;
    dt = t - s.ramp_ms;
    trav_sum = {1'b0, div_quo[41:0]} + {11'd0, TRAVEL_MARGIN_MS};
    lim_trav = (trav_sum[42:32] != '0) ? 32'hFFFF_FFFF : trav_sum[31:0];
    noend_sum = {2'd0, lim_trav} + {2'd0, dwell_r} + {2'd0, NO_END_MARGIN_MS};
    lim_noend = (NO_END_LIMIT_MS != '0) ? NO_END_LIMIT_MS :
                (noend_sum[33:32] != '0) ? 32'hFFFF_FFFF : noend_sum[31:0];
    lim_move = (s.travel != '0) ? lim_trav : travel_to_r;
    vmin64 = {40'd0, min_speed_r, 8'd0};
    vmax64 = {40'd0, max_speed_r, 8'd0};
    v = {40'd0, s.speed_now};
    want = {40'd0, s.speed_goal};
    delta = {38'd0, ramp_delta};

    case (cmd.phase)
      PH_LOAD: halt_nxt = 1'b0;

      PH_PRE: begin
        s.o_pulse = 1'b0;
        s.o_dir = 1'b0;
        s.o_event = 1'b0;
        if (sys_r && !s.prev_act) begin
          s.pulse_ms = t;
          s.end_hit = t;
        end
        s.prev_act = sys_r;
        if (!sys_r) begin
          s.speed_goal = '0;
          s.speed_now = '0;
        end
        if (act_r == A_STOP) s = f_stopped(s, t);
        if (act_r == A_HOME) s = f_homing(s, 1'b1, min_speed_r, t, tu);
        if (act_r == A_FAULT) begin
          s = f_fault(s, fcode_r, t);
          halt_nxt = 1'b1;
        end else begin
          if (act_r == A_LEFT) s = f_forced(s, 1'b0, min_speed_r, t, tu);
          if (act_r == A_RIGHT) s = f_forced(s, 1'b1, min_speed_r, t, tu);
          if (act_r == A_START && s.mode == M_STOPPED) s = f_homing(s, 1'b1, min_speed_r, t, tu);
          if (hl && !s.prev_hl) s.end_hit = t;
          if (hr && !s.prev_hr) s.end_hit = t;
          s.prev_hl = hl;
          s.prev_hr = hr;
          if (s.end_hit == '0) s.end_hit = t;
          if (hl && hr) begin
            if (s.both_since == '0) s.both_since = t;
            if ((t - s.both_since) >= BOTH_DEBOUNCE_MS) begin
              s = f_fault(s, E_BOTH, t);
              halt_nxt = 1'b1;
            end
          end else begin
            s.both_since = '0;
          end
          if (!halt_nxt) begin
            if (!sys_r) begin
              if (s.mode != M_STOPPED) s = f_stopped(s, t);
              halt_nxt = 1'b1;
            end else if (s.mode == M_STOPPED) begin
              s.speed_now = '0;
              s.speed_goal = '0;
              halt_nxt = 1'b1;
            end
          end
        end
      end

      PH_MID: begin
        if ((s.mode inside {M_HOMING, M_CALIB, M_LEFT, M_RIGHT}) &&
            ((t - s.pulse_ms) > stall_r)) begin
          s = f_fault(s, E_STALL, t);
          halt_nxt = 1'b1;
        end else if ((t - s.end_hit) > lim_noend) begin
          s = f_fault(s, E_STALL, t);
          halt_nxt = 1'b1;
        end else if (s.mode == M_RECOVER) begin
          if (!s.locked && ((t - s.enter) >= HOLD_MS)) s = f_homing(s, 1'b0, min_speed_r, t, tu);
          halt_nxt = 1'b1;
        end else if (s.mode == M_FAULT) begin
          if (s.retry >= MAX_RETRIES) s.locked = 1'b1;
          else if ((t - s.enter) >= HOLD_MS) begin
            s.mode = M_RECOVER;
            s.enter = t;
          end
          halt_nxt = 1'b1;
        end else if (s.mode == M_HOMING && ((t - s.enter) > homing_to_r)) begin
          s = f_fault(s, E_HOMING, t);
          halt_nxt = 1'b1;
        end else if (s.mode == M_CALIB && ((t - s.enter) > travel_to_r)) begin
          s = f_fault(s, E_CALIB, t);
          halt_nxt = 1'b1;
        end else if ((s.mode == M_LEFT || s.mode == M_RIGHT) && ((t - s.enter) > lim_move)) begin
          s = f_fault(s, E_TRAVEL, t);
          halt_nxt = 1'b1;
        end else if (s.mode == M_DWELL) begin
          s.speed_now = '0;
          if ((t - s.enter) < dwell_r) halt_nxt = 1'b1;
        end else begin
          s.speed_goal = (s.mode == M_HOMING) ? {min_speed_r, 8'd0} : {max_speed_r, 8'd0};
        end
      end

      PH_RAMP: begin
        if (s.mode == M_DWELL) begin
          // dwell over: rehome on a whole number of periods, else resume
          if (s.cycles != '0 && div_rem == '0) begin
            s = f_homing(s, 1'b1, min_speed_r, t, tu);
          end else begin
            s.mode = s.resume;
            s.enter = t;
            s.moves = '0;
            s.step_us = tu;
            if (s.resume == M_LEFT) s.right_seen = 1'b1;
          end
          halt_nxt = 1'b1;
        end else if (dt != '0) begin
          s.ramp_ms = t;
          if ((s.mode == M_LEFT || s.mode == M_RIGHT) && s.travel != '0) begin
            brake = (ra_r <= 52'h0_0000_8000_0000) && ({ra_r[31:0], 17'd0} <= {1'b0, vv_r});
            want = brake ? vmin64 : vmax64;
          end
          if (v < want) begin
            v = v + delta;
            if (v > want) v = want;
          end else if (v > want) begin
            v = ((v - want) <= delta) ? want : (v - delta);
          end
          if (v < vmin64) v = vmin64;
          if (v > vmax64) v = vmax64;
          s.speed_now = v[23:0];
        end
      end

      PH_FIN: begin
        right = (s.mode == M_CALIB || s.mode == M_RIGHT);
        s.o_dir = right;
        if ((tu - s.step_us) >= div_quo[31:0]) begin
          s.o_pulse = 1'b1;
          s.step_us = tu;
          s.pulse_ms = t;
          s.pos = right ? (s.pos + 32'd1) : (s.pos - 32'd1);
          if (s.mode == M_CALIB) s.calib = s.calib + 32'd1;
          else if (s.mode != M_HOMING) s.moves = s.moves + 32'd1;
        end
        case (s.mode)
          M_HOMING: begin
            if (s.prev_hl) begin
              s.pos = '0;
              s.speed_now = '0;
              s.speed_goal = {min_speed_r, 8'd0};
              s.travel = '0;
              s.mode = M_CALIB;
              s.enter = t;
              s.step_us = tu;
              s.err = E_NONE;
              s.calib = '0;
              s.moves = '0;
            end
          end
          M_CALIB: begin
            if (s.prev_hr) begin
              s.travel = s.calib;
              s.calib = '0;
              s = f_dwell(s, M_LEFT, t);
            end
          end
          M_RIGHT: if (s.prev_hr) s = f_dwell(s, M_LEFT, t);
          M_LEFT: begin
            if (s.prev_hl) begin
              if (s.right_seen) begin
                s.cycles = s.cycles + 32'd1;
                s.right_seen = 1'b0;
              end
              s = f_dwell(s, M_RIGHT, t);
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase
    st_nxt = s;
  end

  always_comb begin
    st_rst = '0;
    st_rst.mode = M_HOMING;
    st_rst.resume = M_STOPPED;
    st_rst.speed_goal = {RST_MIN_SPEED, 8'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
      halt_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      halt_r <= halt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_step_pulse <= st_r.o_pulse;
      out_step_dir <= st_r.o_dir;
      out_motor_enable <= (st_r.mode inside {M_HOMING, M_CALIB, M_LEFT, M_RIGHT});
      out_motion_state <= st_r.mode;
      out_error_code <= st_r.err;
      out_position <= st_r.pos;
      out_cycle_count <= st_r.cycles;
      out_current_speed <= st_r.speed_now;
      out_travel_steps <= st_r.travel;
      out_permanent_fault <= st_r.locked;
      out_fault_event <= st_r.o_event;
    end
  end

  assign st.halt = halt_r;
  assign st.div_busy = div_busy;

endmodule

// ----- sv/stepper_shuttle_limit_controller_unit.sv -----
// Stepper shuttle controller between two limit sensors.
// Input channel (in_valid/in_ready): one control tick per transfer, with
// time stamps, raw sensor levels, the system enable and an optional command.
// Result channel (out_valid/out_ready): exactly one result per tick: step
// pulse and direction, motor enable, motion state, error, position, cycle
// count, current speed (16.8), learned travel and fault flags.
// Configuration port: cfg_we writes cfg_wdata into register cfg_index at
// the clock edge; write only while no tick is in flight.
// One tick at a time. A moving tick runs the shared bit-serial divider for
// the time limit, then for the step interval; the ramp increment is a
// registered reciprocal product. A dwell tick that ends its pause runs the
// divider for the time limit and the modulo; ticks ending early skip the
// divisions (command fault, stop, both sensors, disabled) or stop after the
// time limit (limit fault, fault hold, dwell still running).
// A new tick is taken only after the previous one has loaded its result.
// Reset (rst_n low, synchronous) restores register defaults and starts in
// homing; no result is pending. A stalled receiver holds the result
// register; the next tick is still taken and held until the result is taken.
module stepper_shuttle_limit_controller_unit
  import sslc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_now_us,
  input  logic        in_hall_left_raw,
  input  logic        in_hall_right_raw,
  input  logic        in_system_active,
  input  logic [2:0]  in_fault_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_step_pulse,
  output logic        out_step_dir,
  output logic        out_motor_enable,
  output logic [2:0]  out_motion_state,
  output logic [2:0]  out_error_code,
  output logic signed [31:0] out_position,
  output logic [31:0] out_cycle_count,
  output logic [23:0] out_current_speed,
  output logic [31:0] out_travel_steps,
  output logic        out_permanent_fault,
  output logic        out_fault_event,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t    cmd;
  status_t st;

  sslc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  sslc_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_action           (in_action),
    .in_now_ms           (in_now_ms),
    .in_now_us           (in_now_us),
    .in_hall_left_raw    (in_hall_left_raw),
    .in_hall_right_raw   (in_hall_right_raw),
    .in_system_active    (in_system_active),
    .in_fault_code       (in_fault_code),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_step_pulse      (out_step_pulse),
    .out_step_dir        (out_step_dir),
    .out_motor_enable    (out_motor_enable),
    .out_motion_state    (out_motion_state),
    .out_error_code      (out_error_code),
    .out_position        (out_position),
    .out_cycle_count     (out_cycle_count),
    .out_current_speed   (out_current_speed),
    .out_travel_steps    (out_travel_steps),
    .out_permanent_fault (out_permanent_fault),
    .out_fault_event     (out_fault_event)
  );

endmodule

// ----- sv/sslc_checker.sv -----
// port-level checks for the stepper shuttle controller, bound to the top level
// depends on sslc_pkg and stepper_shuttle_limit_controller_unit
module sslc_checker
  import sslc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_motor_enable,
  input logic [2:0]  out_motion_state,
  input logic        out_fault_event,
  input logic signed [31:0] out_position
);

  // one tick at a time: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_position)))
    else $error("stalled result changed");

  a_enable_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_motor_enable == (out_motion_state == M_HOMING ||
                                        out_motion_state == M_CALIB ||
                                        out_motion_state == M_LEFT ||
                                        out_motion_state == M_RIGHT)))
    else $error("motor enable disagrees with motion state");

  a_event_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault_event) |-> (out_motion_state == M_FAULT && !out_motor_enable))
    else $error("fault event outside fault state");

endmodule

bind stepper_shuttle_limit_controller_unit sslc_checker u_sslc_checker (.*);
